// ----- hw/rtl/pfr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the palette fade remap block: payload types and constants.
package pfr_pkg;

   localparam int PAL_DEPTH    = 256;
   localparam int SEARCH_COUNT = 16;
   localparam int GROUP_SIZE   = 4;
   localparam int NUM_GROUPS   = (SEARCH_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int CAND_W       = (SEARCH_COUNT > 1) ? $clog2(SEARCH_COUNT) : 1;
   localparam logic [7:0] SEARCH_BASE = 8'(PAL_DEPTH - SEARCH_COUNT);

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register indexes, decoded from paddr[2]
   localparam logic REG_TARGET = 1'b0;
   localparam logic REG_FADE   = 1'b1;

   // channel 2 is red, 1 green, 0 blue
   typedef logic [2:0][7:0] rgb_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] entry_index;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_item_type;

   typedef struct packed {
      logic [7:0] source_index;
      logic [7:0] remap_value;
   } rsp_item_type;

endpackage

// ----- hw/rtl/palette_fade_remap.sv -----
`timescale 1ns / 1ps
// Palette fade remap: palette store, fade arithmetic and nearest-color pipeline.
// Path: a query beat passes the stage 1 to 6 registers, then the result register.
// Throughput: one beat per cycle while no result waits on rsp_ready; the palette RAM reads source and target at accept.
// The pipeline stalls as a whole only while a result waits on rsp_ready.
// Reset: synchronous, clears valid bits and both registers; palette is undefined.
module palette_fade_remap
   import pfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_payload,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   // Configuration registers
   logic [7:0] target_ff;
   logic [7:0] fade_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         fade_ff   <= '0;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == REG_TARGET) begin
            target_ff <= pwdata[7:0];
         end else begin
            fade_ff <= pwdata[7:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_TARGET) begin
         prdata = {24'd0, target_ff};
      end else begin
         prdata = {24'd0, fade_ff};
      end
   end

   // Whole pipeline advances together; hold everything while a result waits.
   logic advance;
   logic rsp_valid_ff;
   rsp_item_type rsp_ff;

   assign advance     = !rsp_valid_ff || rsp_ready;
   assign req_ready   = advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   logic    accept;
   rgb_type req_rgb;
   assign accept  = req_valid && advance;
   assign req_rgb = {req_payload.red_in, req_payload.green_in, req_payload.blue_in};

   // Stage 1: palette RAM, written and read at accept. A write lands before
   // any later beat reads, so a query always sees earlier writes.
   rgb_type      pal_mem [PAL_DEPTH];
   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   rgb_type      s1_src_ff;
   rgb_type      s1_tgt_ff;

   always_ff @(posedge clock) begin
      if (accept && req_payload.req_type == REQ_WRITE) begin
         pal_mem[req_payload.entry_index] <= req_rgb;
      end
      if (advance) begin
         s1_src_ff  <= pal_mem[req_payload.entry_index];
         s1_tgt_ff  <= pal_mem[target_ff];
         s1_item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Stage 2: distance to target times the fade step
   logic [6:0]      fade_step;
   logic            s2_valid_ff;
   req_item_type    s2_item_ff;
   logic [2:0]      s2_ge_ff,   s2_ge_in;
   rgb_type         s2_orig_ff;
   logic [2:0][14:0] s2_prod_ff, s2_prod_in;

   assign fade_step = fade_ff[7:1];

   always_comb begin
      logic [7:0] diff;
      for (int c = 0; c < 3; c++) begin
         s2_ge_in[c] = s1_src_ff[c] >= s1_tgt_ff[c];
         diff = s2_ge_in[c] ? (s1_src_ff[c] - s1_tgt_ff[c]) : (s1_tgt_ff[c] - s1_src_ff[c]);
         s2_prod_in[c] = 15'(diff) * 15'(fade_step);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_item_ff <= s1_item_ff;
         s2_ge_ff   <= s2_ge_in;
         s2_orig_ff <= s1_src_ff;
         s2_prod_ff <= s2_prod_in;
      end
   end

   // Stage 3: faded color; floor shift moving down, ceiling shift moving up, so the result rounds up
   logic         s3_valid_ff;
   req_item_type s3_item_ff;
   rgb_type      s3_faded_ff, s3_faded_in;

   always_comb begin
      logic [15:0] up;
      for (int c = 0; c < 3; c++) begin
         up = 16'(s2_prod_ff[c]) + 16'd127;
         if (s2_ge_ff[c]) begin
            s3_faded_in[c] = s2_orig_ff[c] - s2_prod_ff[c][14:7];
         end else begin
            s3_faded_in[c] = s2_orig_ff[c] + up[14:7];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_item_ff  <= s2_item_ff;
         s3_faded_ff <= s3_faded_in;
      end
   end

   // Candidate copy of the search entries, updated in program order at stage 3
   rgb_type cand_ff [SEARCH_COUNT];
   rgb_type s3_rgb;
   assign s3_rgb = {s3_item_ff.red_in, s3_item_ff.green_in, s3_item_ff.blue_in};

   always_ff @(posedge clock) begin
      if (advance && s3_valid_ff && s3_item_ff.req_type == REQ_WRITE) begin
         for (int k = 0; k < SEARCH_COUNT; k++) begin
            if (s3_item_ff.entry_index == 8'(PAL_DEPTH - SEARCH_COUNT + k)) begin
               cand_ff[k] <= s3_rgb;
            end
         end
      end
   end

   // Stage 4: squared channel differences for every candidate
   logic         s4_valid_ff;
   req_item_type s4_item_ff;
   logic [2:0][15:0] s4_sq_ff [SEARCH_COUNT];
   logic [2:0][15:0] s4_sq_in [SEARCH_COUNT];

   always_comb begin
      logic [7:0] d;
      for (int k = 0; k < SEARCH_COUNT; k++) begin
         for (int c = 0; c < 3; c++) begin
            d = (cand_ff[k][c] >= s3_faded_ff[c]) ? (cand_ff[k][c] - s3_faded_ff[c])
                                                  : (s3_faded_ff[c] - cand_ff[k][c]);
            s4_sq_in[k][c] = 16'(d) * 16'(d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_item_ff <= s3_item_ff;
         s4_sq_ff   <= s4_sq_in;
      end
   end

   // Stage 5: sum of squares
   logic         s5_valid_ff;
   req_item_type s5_item_ff;
   logic [17:0]  s5_dist_ff [SEARCH_COUNT];
   logic [17:0]  s5_dist_in [SEARCH_COUNT];

   always_comb begin
      for (int k = 0; k < SEARCH_COUNT; k++) begin
         s5_dist_in[k] = 18'(s4_sq_ff[k][2]) + 18'(s4_sq_ff[k][1]) + 18'(s4_sq_ff[k][0]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_item_ff <= s4_item_ff;
         s5_dist_ff <= s5_dist_in;
      end
   end

   // Stage 6: minimum within each group; only a strictly smaller distance wins
   logic              s6_valid_ff;
   req_item_type      s6_item_ff;
   logic [17:0]       s6_dist_ff [NUM_GROUPS];
   logic [CAND_W-1:0] s6_idx_ff  [NUM_GROUPS];
   logic [17:0]       s6_dist_in [NUM_GROUPS];
   logic [CAND_W-1:0] s6_idx_in  [NUM_GROUPS];

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         s6_dist_in[g] = s5_dist_ff[g * GROUP_SIZE];
         s6_idx_in[g]  = CAND_W'(g * GROUP_SIZE);
         for (int j = 1; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < SEARCH_COUNT) begin
               if (s5_dist_ff[g * GROUP_SIZE + j] < s6_dist_in[g]) begin
                  s6_dist_in[g] = s5_dist_ff[g * GROUP_SIZE + j];
                  s6_idx_in[g]  = CAND_W'(g * GROUP_SIZE + j);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_item_ff <= s5_item_ff;
         s6_dist_ff <= s6_dist_in;
         s6_idx_ff  <= s6_idx_in;
      end
   end

   // Stage 7: minimum across groups, then the fixed mappings
   rsp_item_type rsp_in;

   always_comb begin
      logic [17:0]       best_dist;
      logic [CAND_W-1:0] best_idx;
      best_dist = s6_dist_ff[0];
      best_idx  = s6_idx_ff[0];
      for (int g = 1; g < NUM_GROUPS; g++) begin
         if (s6_dist_ff[g] < best_dist) begin
            best_dist = s6_dist_ff[g];
            best_idx  = s6_idx_ff[g];
         end
      end
      rsp_in.source_index = s6_item_ff.entry_index;
      if (s6_item_ff.entry_index == 8'd0) begin
         rsp_in.remap_value = 8'd0;
      end else if (s6_item_ff.entry_index >= SEARCH_BASE) begin
         rsp_in.remap_value = s6_item_ff.entry_index;
      end else begin
         rsp_in.remap_value = SEARCH_BASE + 8'(best_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Valid bits; writes drop out as they leave stage 6
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= s6_valid_ff && s6_item_ff.req_type == REQ_QUERY;
      end
   end

endmodule
